@@ sv/track_covariance_jacobian_transform_unit_defines.svh @@
// Assertion macros for the track covariance Jacobian transform unit.
// Depends on nothing; the including module supplies clock and reset.
`ifndef TRACK_COVARIANCE_JACOBIAN_TRANSFORM_UNIT_DEFINES_SVH
`define TRACK_COVARIANCE_JACOBIAN_TRANSFORM_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TCJT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcjt same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TCJT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcjt next-cycle check failed");

`endif

@@ sv/tcjt_pkg.sv @@
// Shared constants, types and helper functions of the covariance transform unit.
// Depends on nothing.
package tcjt_pkg;

   localparam int unsigned N_OUT = 21;
   localparam logic [4:0] LAST_INDEX = 5'(N_OUT - 1);
   localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO_QP = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   // scalar program steps
   localparam logic [4:0] PC_TXS  = 5'd0;
   localparam logic [4:0] PC_TYS  = 5'd1;
   localparam logic [4:0] PC_SQRT = 5'd2;
   localparam logic [4:0] PC_ST   = 5'd3;
   localparam logic [4:0] PC_PM   = 5'd4;
   localparam logic [4:0] PC_AM   = 5'd5;
   localparam logic [4:0] PC_QT   = 5'd6;
   localparam logic [4:0] PC_BM   = 5'd7;
   localparam logic [4:0] PC_TXY  = 5'd8;
   localparam logic [4:0] PC_F32  = 5'd9;
   localparam logic [4:0] PC_F33  = 5'd10;
   localparam logic [4:0] PC_F34  = 5'd11;
   localparam logic [4:0] PC_F42  = 5'd12;
   localparam logic [4:0] PC_F43  = 5'd13;
   localparam logic [4:0] PC_F44  = 5'd14;
   localparam logic [4:0] PC_F52  = 5'd15;
   localparam logic [4:0] PC_F53  = 5'd16;
   localparam logic [4:0] PC_DONE = 5'd17;

   typedef struct packed {
      logic signed [63:0] value;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat64(input logic signed [127:0] x);
      sat_type r;
      if ((&x[127:63]) || !(|x[127:63])) begin
         r.value = x[63:0];
         r.ovf   = 1'b0;
      end else begin
         r.value = x[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         r.ovf   = 1'b1;
      end
      return r;
   endfunction

   function automatic sat_type signed_of(input logic [63:0] m, input logic neg);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (m > {1'b1, 63'd0}) begin
            r.value = {1'b1, 63'd0};
            r.ovf   = 1'b1;
         end else begin
            r.value = -$signed(m);
         end
      end else begin
         if (m[63]) begin
            r.value = {1'b0, {63{1'b1}}};
            r.ovf   = 1'b1;
         end else begin
            r.value = $signed(m);
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // packed lower-triangle slot of a symmetric 5x5 entry
   function automatic logic [4:0] cov_slot(input logic [2:0] a, input logic [2:0] b);
      logic [2:0] lo;
      logic [2:0] hi;
      logic [4:0] base;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      unique case (hi)
         3'd0:    base = 5'd0;
         3'd1:    base = 5'd1;
         3'd2:    base = 5'd3;
         3'd3:    base = 5'd6;
         default: base = 5'd10;
      endcase
      return base + {2'd0, lo};
   endfunction

endpackage

@@ sv/track_covariance_jacobian_transform_unit.sv @@
// Top level of the track covariance Jacobian transform unit.
// Depends on tcjt_pkg and track_covariance_jacobian_transform_unit_defines.svh.
`include "track_covariance_jacobian_transform_unit_defines.svh"

// Track covariance transform from (x, y, tx, ty, q/p) to (x, y, z, px, py, pz).
// A load word (command 0) writes one packed covariance entry; an
// index above 20 is dropped. A compute word (command 1) raises busy and produces
// 21 result words, packed lower-triangle order, last_entry on the 21st. In
// pass-through mode the 21 stored entries are echoed, one word per cycle.
// With q/p zero the 21 words carry value 0 and status 1, one per cycle.
// Otherwise the block runs a short scalar program (squares, integer square root,
// three 128/64 divides, the Jacobian products), then V*F^T (150 products) and
// F*(V*F^T) (105 products). The pace of a compute word is set by the one 32x32
// multiplier that builds every 64x64 product from four partial products, and by
// the bit-per-cycle divider. Each word is on the rsp_ ports for one cycle only
// and the receiver cannot stall it. Status 2 marks an entry whose sum, Jacobian
// row or intermediate column saturated. Entries never loaded read as anything.
// csr_write_data selects pass-through; write it only while idle.
module track_covariance_jacobian_transform_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [4:0]         req_element_index,
   input  logic signed [63:0] req_element_value,
   input  logic signed [31:0] req_tx_slope,
   input  logic signed [31:0] req_ty_slope,
   input  logic signed [31:0] req_q_over_p,
   input  logic signed [1:0]  req_charge,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   output logic [4:0]         rsp_out_index,
   output logic signed [63:0] rsp_out_value,
   output logic               rsp_last_entry,
   output logic [1:0]         rsp_status
);
   import tcjt_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PASS  = 4'd1;
   localparam logic [3:0] S_ZERO  = 4'd2;
   localparam logic [3:0] S_DISP  = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_DPOST = 4'd6;
   localparam logic [3:0] S_MSET  = 4'd7;
   localparam logic [3:0] S_MRUN  = 4'd8;
   localparam logic [3:0] S_MNEG  = 4'd9;
   localparam logic [3:0] S_MPOST = 4'd10;
   localparam logic [3:0] S_VSAT  = 4'd11;
   localparam logic [3:0] S_OSAT  = 4'd12;

   localparam logic [1:0] PH_SCAL = 2'd0;
   localparam logic [1:0] PH_VFT  = 2'd1;
   localparam logic [1:0] PH_OUT  = 2'd2;

   // control
   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [4:0] pc_ff, pc_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] col_ff, col_in;
   logic [2:0] term_ff, term_in;
   logic [4:0] idx_ff, idx_in;
   logic       pass_mode_ff, pass_mode_in;
   logic [1:0] mstep_ff, mstep_in;
   logic [5:0] dv_cnt_ff, dv_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [31:0]  tx_ff, tx_in, ty_ff, ty_in, qv_ff, qv_in;
   logic [1:0]          chg_ff, chg_in;
   logic [63:0]         txs_ff, txs_in, tys_ff, tys_in, s_ff, s_in;
   logic [31:0]         t_ff, t_in;
   logic [63:0]         t3_ff, t3_in, qt_ff, qt_in, pm_ff, pm_in;
   logic signed [63:0]  a_ff, a_in, b_ff, b_in, txy_ff, txy_in;
   logic [63:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic                mneg_ff, mneg_in;
   logic signed [127:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [5:0]          rs_ff, rs_in, cs_ff, cs_in;
   logic [63:0]         dv_r_ff, dv_r_in, dv_n_ff, dv_n_in, dv_d_ff, dv_d_in;
   logic [63:0]         dv_q_ff, dv_q_in;
   logic                dv_sat_ff, dv_sat_in;
   logic [63:0]         sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [4:0]          rsp_idx_ff, rsp_idx_in;
   logic signed [63:0]  rsp_val_ff, rsp_val_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [1:0]          rsp_stat_ff, rsp_stat_in;

   // storage
   logic signed [63:0] cov_ff [N_OUT];
   logic signed [63:0] f_ff   [6][5];
   logic signed [63:0] vft_ff [5][6];

   logic               cov_we;
   logic               f_init;
   logic               f_we;
   logic [2:0]         f_row, f_col;
   logic signed [63:0] f_wdata;
   logic               vft_we;

   // datapath helpers
   logic [1:0]          cmag;
   logic                chg_pos, chg_neg;
   logic [31:0]         qv_mag;
   logic signed [63:0]  tx32, ty32, one_txx, one_tyy, na;
   logic signed [127:0] sh;
   logic signed [127:0] acc_sum;
   sat_type             fm, acc_sat, b_conv;
   logic [31:0]         a_half, b_half;
   logic [63:0]         partial;
   logic [127:0]        partial_sh;
   logic [63:0]         op_x, op_y;
   logic                op_uns;
   logic [63:0]         sq_sum;
   logic [63:0]         dv_rsh;
   logic                dv_take;
   logic [63:0]         nhi, nlo, dd;
   logic                accept;

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_idx_ff;
   assign rsp_out_value  = rsp_val_ff;
   assign rsp_last_entry = rsp_last_ff;
   assign rsp_status     = rsp_stat_ff;

   always_comb begin
      unique case (chg_ff)
         2'b00:   cmag = 2'd0;
         2'b10:   cmag = 2'd2;
         default: cmag = 2'd1;
      endcase
      chg_pos    = (chg_ff == 2'b01);
      chg_neg    = chg_ff[1];
      qv_mag     = qv_ff[31] ? 32'(-qv_ff) : 32'(qv_ff);
      tx32       = {{24{tx_ff[31]}}, tx_ff, 8'd0};
      ty32       = {{24{ty_ff[31]}}, ty_ff, 8'd0};
      one_txx    = ONE_Q32 + $signed({16'd0, txs_ff[63:16]});
      one_tyy    = ONE_Q32 + $signed({16'd0, tys_ff[63:16]});
      na         = -a_ff;
      sh         = prod_ff >>> 32;
      fm         = sat64(sh);
      acc_sum    = acc_ff + sh;
      acc_sat    = sat64(acc_ff);
      b_conv     = signed_of(dv_q_ff, chg_pos);
      // one 32x32 partial product per step
      a_half     = mstep_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_half     = mstep_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      partial    = a_half * b_half;
      unique case (mstep_ff)
         2'd0:    partial_sh = {64'd0, partial};
         2'd3:    partial_sh = {partial, 64'd0};
         default: partial_sh = {32'd0, partial, 32'd0};
      endcase
      sq_sum     = sq_res_ff + sq_bit_ff;
      dv_rsh     = {dv_r_ff[62:0], dv_n_ff[63]};
      dv_take    = dv_r_ff[63] || (dv_rsh >= dv_d_ff);
   end

   // multiplier operand select
   always_comb begin
      op_x   = '0;
      op_y   = '0;
      op_uns = 1'b0;
      unique case (phase_ff)
         PH_VFT: begin
            op_x = cov_ff[cov_slot(row_ff, term_ff)];
            op_y = f_ff[col_ff][term_ff];
         end
         PH_OUT: begin
            op_x = f_ff[row_ff][term_ff];
            op_y = vft_ff[term_ff][col_ff];
         end
         default: begin
            unique case (pc_ff)
               PC_TXS: begin
                  op_x = {{32{tx_ff[31]}}, tx_ff};
                  op_y = {{32{tx_ff[31]}}, tx_ff};
               end
               PC_TYS: begin
                  op_x = {{32{ty_ff[31]}}, ty_ff};
                  op_y = {{32{ty_ff[31]}}, ty_ff};
               end
               PC_ST: begin
                  op_x   = s_ff;
                  op_y   = {32'd0, t_ff};
                  op_uns = 1'b1;
               end
               PC_QT: begin
                  op_x   = {32'd0, qv_mag};
                  op_y   = {32'd0, t_ff};
                  op_uns = 1'b1;
               end
               PC_TXY: begin op_x = tx32; op_y = ty32; end
               PC_F32: begin op_x = a_ff; op_y = one_tyy; end
               PC_F33: begin op_x = na;   op_y = txy_ff;  end
               PC_F34: begin op_x = b_ff; op_y = tx32;    end
               PC_F42: begin op_x = na;   op_y = txy_ff;  end
               PC_F43: begin op_x = a_ff; op_y = one_txx; end
               PC_F44: begin op_x = b_ff; op_y = ty32;    end
               PC_F52: begin op_x = na;   op_y = tx32;    end
               PC_F53: begin op_x = na;   op_y = ty32;    end
               default: begin op_x = '0; op_y = '0; end
            endcase
         end
      endcase
   end

   // divider operands per program step
   always_comb begin
      unique case (pc_ff)
         PC_AM: begin
            nhi = {32'd0, pm_ff[63:32]};
            nlo = {pm_ff[31:0], 32'd0};
            dd  = t3_ff;
         end
         PC_BM: begin
            nhi = {16'd0, pm_ff[63:16]};
            nlo = {pm_ff[15:0], 48'd0};
            dd  = qt_ff;
         end
         default: begin
            nhi = '0;
            nlo = {6'd0, cmag, 56'd0};
            dd  = {32'd0, qv_mag};
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pc_in        = pc_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      term_in      = term_ff;
      idx_in       = idx_ff;
      pass_mode_in = csr_write_enable ? csr_write_data : pass_mode_ff;
      mstep_in     = mstep_ff;
      dv_cnt_in    = dv_cnt_ff;
      rsp_valid_in = 1'b0;
      tx_in = tx_ff; ty_in = ty_ff; qv_in = qv_ff; chg_in = chg_ff;
      txs_in = txs_ff; tys_in = tys_ff; s_in = s_ff; t_in = t_ff;
      t3_in = t3_ff; qt_in = qt_ff; pm_in = pm_ff;
      a_in = a_ff; b_in = b_ff; txy_in = txy_ff;
      ma_in = ma_ff; mb_in = mb_ff; mneg_in = mneg_ff;
      prod_in = prod_ff; acc_in = acc_ff;
      rs_in = rs_ff; cs_in = cs_ff;
      dv_r_in = dv_r_ff; dv_n_in = dv_n_ff; dv_d_in = dv_d_ff;
      dv_q_in = dv_q_ff; dv_sat_in = dv_sat_ff;
      sq_v_in = sq_v_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      rsp_idx_in = rsp_idx_ff; rsp_val_in = rsp_val_ff;
      rsp_last_in = rsp_last_ff; rsp_stat_in = rsp_stat_ff;
      cov_we  = 1'b0;
      f_init  = 1'b0;
      f_we    = 1'b0;
      f_row   = '0;
      f_col   = '0;
      f_wdata = fm.value;
      vft_we  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LOAD) begin
                  cov_we = (req_element_index < 5'(N_OUT));
               end else begin
                  tx_in  = req_tx_slope;
                  ty_in  = req_ty_slope;
                  qv_in  = req_q_over_p;
                  chg_in = req_charge;
                  idx_in = '0;
                  if (pass_mode_ff) begin
                     state_in = S_PASS;
                  end else if (req_q_over_p == '0) begin
                     state_in = S_ZERO;
                  end else begin
                     f_init   = 1'b1;
                     phase_in = PH_SCAL;
                     pc_in    = PC_TXS;
                     rs_in    = '0;
                     cs_in    = '0;
                     state_in = S_DISP;
                  end
               end
            end
         end

         S_PASS, S_ZERO: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = idx_ff;
            rsp_val_in   = (state_ff == S_PASS) ? cov_ff[idx_ff] : '0;
            rsp_last_in  = (idx_ff == LAST_INDEX);
            rsp_stat_in  = (state_ff == S_PASS) ? STATUS_OK : STATUS_ZERO_QP;
            idx_in       = idx_ff + 5'd1;
            if (idx_ff == LAST_INDEX) state_in = S_IDLE;
         end

         S_DISP: begin
            unique case (pc_ff)
               PC_SQRT: begin
                  s_in      = (64'd1 << 48) + txs_ff + tys_ff;
                  sq_v_in   = (64'd1 << 48) + txs_ff + tys_ff;
                  sq_res_in = '0;
                  sq_bit_in = 64'd1 << 62;
                  state_in  = S_SQRT;
               end
               PC_PM, PC_AM, PC_BM: begin
                  dv_r_in   = nhi;
                  dv_n_in   = nlo;
                  dv_d_in   = dd;
                  dv_q_in   = '0;
                  dv_sat_in = (nhi >= dd);
                  dv_cnt_in = '0;
                  state_in  = S_DIV;
               end
               PC_DONE: begin
                  phase_in = PH_VFT;
                  row_in   = '0;
                  col_in   = '0;
                  term_in  = '0;
                  acc_in   = '0;
                  state_in = S_MSET;
               end
               default: state_in = S_MSET;
            endcase
         end

         S_SQRT: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_in   = sq_v_ff - sq_sum;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               t_in     = sq_res_in[31:0];
               pc_in    = pc_ff + 5'd1;
               state_in = S_DISP;
            end
         end

         S_DIV: begin
            if (dv_sat_ff) begin
               dv_q_in  = '1;
               state_in = S_DPOST;
            end else begin
               dv_r_in   = dv_take ? (dv_rsh - dv_d_ff) : dv_rsh;
               dv_n_in   = dv_n_ff << 1;
               dv_q_in   = {dv_q_ff[62:0], dv_take};
               dv_cnt_in = dv_cnt_ff + 6'd1;
               if (dv_cnt_ff == 6'd63) state_in = S_DPOST;
            end
         end

         S_DPOST: begin
            unique case (pc_ff)
               PC_PM: pm_in = dv_q_ff;
               PC_AM: a_in = (chg_neg ^ qv_ff[31]) ? -$signed(dv_q_ff) : $signed(dv_q_ff);
               default: begin
                  b_in    = b_conv.value;
                  f_we    = 1'b1;
                  f_row   = 3'd5;
                  f_col   = 3'd4;
                  f_wdata = b_conv.value;
                  if (dv_sat_ff || b_conv.ovf) rs_in[5:3] = 3'b111;
               end
            endcase
            pc_in    = pc_ff + 5'd1;
            state_in = S_DISP;
         end

         S_MSET: begin
            ma_in    = op_uns ? op_x : mag64(op_x);
            mb_in    = op_uns ? op_y : mag64(op_y);
            mneg_in  = !op_uns && (op_x[63] ^ op_y[63]);
            prod_in  = '0;
            mstep_in = '0;
            state_in = S_MRUN;
         end

         S_MRUN: begin
            prod_in  = prod_ff + $signed(partial_sh);
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) state_in = S_MNEG;
         end

         S_MNEG: begin
            if (mneg_ff) prod_in = -prod_ff;
            state_in = S_MPOST;
         end

         S_MPOST: begin
            if (phase_ff == PH_SCAL) begin
               unique case (pc_ff)
                  PC_TXS: txs_in = prod_ff[63:0];
                  PC_TYS: tys_in = prod_ff[63:0];
                  PC_ST:  t3_in  = prod_ff[103:40];
                  PC_QT:  qt_in  = prod_ff[63:0];
                  PC_TXY: txy_in = fm.value;
                  PC_F32, PC_F33, PC_F34: begin
                     f_we  = 1'b1;
                     f_row = 3'd3;
                     f_col = 3'(pc_ff - PC_F32 + 5'd2);
                     rs_in[3] = rs_ff[3] | fm.ovf;
                  end
                  PC_F42, PC_F43, PC_F44: begin
                     f_we  = 1'b1;
                     f_row = 3'd4;
                     f_col = 3'(pc_ff - PC_F42 + 5'd2);
                     rs_in[4] = rs_ff[4] | fm.ovf;
                  end
                  default: begin
                     f_we  = 1'b1;
                     f_row = 3'd5;
                     f_col = 3'(pc_ff - PC_F52 + 5'd2);
                     rs_in[5] = rs_ff[5] | fm.ovf;
                  end
               endcase
               pc_in    = pc_ff + 5'd1;
               state_in = S_DISP;
            end else begin
               acc_in = acc_sum;
               if (term_ff == 3'd4) begin
                  term_in  = '0;
                  state_in = (phase_ff == PH_VFT) ? S_VSAT : S_OSAT;
               end else begin
                  term_in  = term_ff + 3'd1;
                  state_in = S_MSET;
               end
            end
         end

         S_VSAT: begin
            vft_we          = 1'b1;
            cs_in[col_ff]   = cs_ff[col_ff] | acc_sat.ovf;
            acc_in          = '0;
            state_in        = S_MSET;
            if (col_ff == 3'd5) begin
               col_in = '0;
               if (row_ff == 3'd4) begin
                  row_in   = '0;
                  phase_in = PH_OUT;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end else begin
               col_in = col_ff + 3'd1;
            end
         end

         S_OSAT: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = idx_ff;
            rsp_val_in   = acc_sat.value;
            rsp_last_in  = (idx_ff == LAST_INDEX);
            rsp_stat_in  = (acc_sat.ovf || rs_ff[row_ff] || rs_ff[col_ff] || cs_ff[col_ff])
                           ? STATUS_SAT : STATUS_OK;
            acc_in       = '0;
            idx_in       = idx_ff + 5'd1;
            if (col_ff == row_ff) begin
               col_in = '0;
               row_in = row_ff + 3'd1;
            end else begin
               col_in = col_ff + 3'd1;
            end
            state_in = (idx_ff == LAST_INDEX) ? S_IDLE : S_MSET;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_SCAL;
         pc_ff        <= PC_TXS;
         row_ff       <= '0;
         col_ff       <= '0;
         term_ff      <= '0;
         idx_ff       <= '0;
         pass_mode_ff <= 1'b0;
         mstep_ff     <= '0;
         dv_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pc_ff        <= pc_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         term_ff      <= term_in;
         idx_ff       <= idx_in;
         pass_mode_ff <= pass_mode_in;
         mstep_ff     <= mstep_in;
         dv_cnt_ff    <= dv_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tx_ff <= tx_in; ty_ff <= ty_in; qv_ff <= qv_in; chg_ff <= chg_in;
      txs_ff <= txs_in; tys_ff <= tys_in; s_ff <= s_in; t_ff <= t_in;
      t3_ff <= t3_in; qt_ff <= qt_in; pm_ff <= pm_in;
      a_ff <= a_in; b_ff <= b_in; txy_ff <= txy_in;
      ma_ff <= ma_in; mb_ff <= mb_in; mneg_ff <= mneg_in;
      prod_ff <= prod_in; acc_ff <= acc_in;
      rs_ff <= rs_in; cs_ff <= cs_in;
      dv_r_ff <= dv_r_in; dv_n_ff <= dv_n_in; dv_d_ff <= dv_d_in;
      dv_q_ff <= dv_q_in; dv_sat_ff <= dv_sat_in;
      sq_v_ff <= sq_v_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      rsp_idx_ff <= rsp_idx_in; rsp_val_ff <= rsp_val_in;
      rsp_last_ff <= rsp_last_in; rsp_stat_ff <= rsp_stat_in;
   end

   // covariance store, Jacobian and intermediate product
   always_ff @(posedge clock) begin
      if (cov_we) cov_ff[req_element_index] <= req_element_value;
      if (f_init) begin
         for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 5; k++) begin
               f_ff[i][k] <= '0;
            end
         end
         f_ff[0][0] <= ONE_Q32;
         f_ff[1][1] <= ONE_Q32;
      end else if (f_we) begin
         f_ff[f_row][f_col] <= f_wdata;
      end
      if (vft_we) vft_ff[row_ff][col_ff] <= acc_sat.value;
   end

   `TCJT_ASSERT_NEXT(a_compute_busy, accept && req_command == CMD_COMPUTE, busy)
   `TCJT_ASSERT_NEXT(a_load_no_busy, accept && req_command == CMD_LOAD, !busy)
   `TCJT_ASSERT_NOW(a_last_index, rsp_valid && rsp_last_entry, rsp_out_index == LAST_INDEX)
   `TCJT_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= STATUS_SAT)

endmodule

@@ sim/tb_track_covariance_jacobian_transform_unit.sv @@
// Self-checking testbench for track_covariance_jacobian_transform_unit.
// Depends on tcjt_pkg and the unit's RTL; a scoreboard class predicts every result word.
`timescale 1ns / 1ps

module tb_track_covariance_jacobian_transform_unit;
   import tcjt_pkg::*;

   typedef struct {
      logic               command;
      logic [4:0]         index;
      logic signed [63:0] value;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] qp;
      logic signed [1:0]  charge;
   } req_word_type;

   typedef struct {
      logic [4:0]         index;
      logic signed [63:0] value;
      logic               last;
      logic [1:0]         status;
   } cov_entry_type;

   // Predicts the packed output covariance of each compute word and checks the
   // result words against it in order.
   class cov_scoreboard_type;
      logic [63:0]   cov_store[N_OUT];
      bit            echo_mode;
      cov_entry_type pending_entries[$];
      int            errors;

      function new();
         echo_mode = 1'b0;
         errors = 0;
         foreach (cov_store[i]) cov_store[i] = '0;
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         errors++;
         $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
      endtask

      function int pending();
         return pending_entries.size();
      endfunction

      function void set_mode(input bit m);
         echo_mode = m;
      endfunction

      function logic signed [127:0] smul(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
         return $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      endfunction

      function logic signed [63:0] clamp(input logic signed [127:0] x, inout bit f);
         if ((&x[127:63]) || !(|x[127:63])) return x[63:0];
         f = 1'b1;
         return x[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      endfunction

      function logic signed [63:0] qmul(input logic signed [63:0] a,
                                        input logic signed [63:0] b, inout bit f);
         return clamp(smul(a, b) >>> 32, f);
      endfunction

      function logic [63:0] quot(input logic [127:0] n, input logic [63:0] d, inout bit f);
         logic [127:0] q;
         if (n[127:64] >= d) begin
            f = 1'b1;
            return '1;
         end
         q = n / {64'd0, d};
         return q[63:0];
      endfunction

      function logic signed [63:0] apply_sign(input logic [63:0] m, input bit neg, inout bit f);
         logic [63:0] lim;
         lim = 64'd1 << 63;
         if (neg) begin
            if (m > lim) begin
               f = 1'b1;
               return {1'b1, 63'd0};
            end
            return -$signed(m);
         end
         if (m >= lim) begin
            f = 1'b1;
            return {1'b0, {63{1'b1}}};
         end
         return $signed(m);
      endfunction

      function logic [63:0] root(input logic [63:0] v);
         logic [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function logic signed [63:0] v_at(input int a, input int b);
         int lo, hi;
         lo = a < b ? a : b;
         hi = a < b ? b : a;
         return $signed(cov_store[lo + hi * (hi + 1) / 2]);
      endfunction

      function void push(input int l, input logic signed [63:0] v, input logic [1:0] st);
         cov_entry_type e;
         e.index = 5'(l);
         e.value = v;
         e.last = (l == N_OUT - 1);
         e.status = st;
         pending_entries = {pending_entries, e};
      endfunction

      function void note_input(input req_word_type w);
         logic signed [63:0] tx, ty, qv, c, a, na, b, tx32, ty32, txx, tyy, txy, ov;
         logic [63:0]        txs, tys, s, t, t3, pm, am, bm, magq, magc;
         logic [127:0]       st;
         logic signed [127:0] acc;
         logic signed [63:0] jac[6][5];
         logic signed [63:0] vft[5][6];
         bit                 rs[6], cs[6];
         bit                 dummy, fb, fs;
         int                 l;
         if (w.command == CMD_LOAD) begin
            if (w.index < N_OUT) cov_store[w.index] = w.value;
            return;
         end
         if (echo_mode) begin
            for (int i = 0; i < N_OUT; i++) push(i, $signed(cov_store[i]), STATUS_OK);
            return;
         end
         tx = w.tx;
         ty = w.ty;
         qv = w.qp;
         c = w.charge;
         if (qv == 0) begin
            for (int i = 0; i < N_OUT; i++) push(i, 64'sd0, STATUS_ZERO_QP);
            return;
         end
         foreach (rs[i]) begin
            rs[i] = 0;
            cs[i] = 0;
         end
         dummy = 0;
         fb = 0;
         txs = tx * tx;
         tys = ty * ty;
         s = (64'd1 << 48) + txs + tys;
         t = root(s);
         st = {64'd0, s} * {64'd0, t};
         t3 = st[103:40];
         magq = qv < 0 ? 64'(-qv) : 64'(qv);
         magc = c < 0 ? 64'(-c) : 64'(c);
         pm = (magc << 56) / magq;
         am = quot({32'd0, pm, 32'd0}, t3, dummy);
         a = ((c < 0) != (qv < 0)) ? -$signed(am) : $signed(am);
         na = -a;
         bm = quot({16'd0, pm, 48'd0}, magq * t, fb);
         b = apply_sign(bm, c > 0, fb);
         if (fb) begin
            rs[3] = 1;
            rs[4] = 1;
            rs[5] = 1;
         end
         tx32 = tx * 256;
         ty32 = ty * 256;
         txx = $signed(txs >> 16);
         tyy = $signed(tys >> 16);
         txy = qmul(tx32, ty32, dummy);
         foreach (jac[i, k]) jac[i][k] = 0;
         jac[0][0] = ONE_Q32;
         jac[1][1] = ONE_Q32;
         jac[3][2] = qmul(a, ONE_Q32 + tyy, rs[3]);
         jac[3][3] = qmul(na, txy, rs[3]);
         jac[3][4] = qmul(b, tx32, rs[3]);
         jac[4][2] = qmul(na, txy, rs[4]);
         jac[4][3] = qmul(a, ONE_Q32 + txx, rs[4]);
         jac[4][4] = qmul(b, ty32, rs[4]);
         jac[5][2] = qmul(na, tx32, rs[5]);
         jac[5][3] = qmul(na, ty32, rs[5]);
         jac[5][4] = b;
         // V*F^T, each product floored to Q16.48 before the exact sum
         for (int k = 0; k < 5; k++)
            for (int j = 0; j < 6; j++) begin
               acc = 0;
               for (int m = 0; m < 5; m++) acc += smul(v_at(k, m), jac[j][m]) >>> 32;
               vft[k][j] = clamp(acc, cs[j]);
            end
         l = 0;
         for (int i = 0; i < 6; i++)
            for (int j = 0; j <= i; j++) begin
               acc = 0;
               fs = 0;
               for (int k = 0; k < 5; k++) acc += smul(jac[i][k], vft[k][j]) >>> 32;
               ov = clamp(acc, fs);
               push(l, ov, (fs || rs[i] || rs[j] || cs[j]) ? STATUS_SAT : STATUS_OK);
               l++;
            end
      endfunction

      task check_result(input logic [4:0] idx, input logic signed [63:0] val,
                        input logic last, input logic [1:0] st);
         cov_entry_type e;
         if (pending_entries.size() == 0) begin
            report("unexpected word, index", 64'(idx), 64'd0);
            return;
         end
         e = pending_entries.pop_front();
         if (idx !== e.index) report("index", 64'(idx), 64'(e.index));
         if (val !== e.value) report("value", val, e.value);
         if (last !== e.last) report("last_entry", 64'(last), 64'(e.last));
         if (st !== e.status) report("status", 64'(st), 64'(e.status));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [4:0]         req_element_index;
   logic signed [63:0] req_element_value;
   logic signed [31:0] req_tx_slope;
   logic signed [31:0] req_ty_slope;
   logic signed [31:0] req_q_over_p;
   logic signed [1:0]  req_charge;
   logic               csr_write_enable;
   logic               csr_write_data;
   logic               rsp_valid;
   logic [4:0]         rsp_out_index;
   logic signed [63:0] rsp_out_value;
   logic               rsp_last_entry;
   logic [1:0]         rsp_status;

   cov_scoreboard_type sb;
   int                 idle_pct;
   int                 words_sent;

   track_covariance_jacobian_transform_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_tx_slope      (req_tx_slope),
      .req_ty_slope      (req_ty_slope),
      .req_q_over_p      (req_q_over_p),
      .req_charge        (req_charge),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_value     (rsp_out_value),
      .rsp_last_entry    (rsp_last_entry),
      .rsp_status        (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample result words at the edge that ends their cycle; values read here are
   // the pre-edge ones, so no ordering race with the block's own updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_out_index, rsp_out_value, rsp_last_entry, rsp_status);
   end

   // Drive one word after a random idle stretch and hold it until the block takes it.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= w.command;
      req_element_index <= w.index;
      req_element_value <= w.value;
      req_tx_slope <= w.tx;
      req_ty_slope <= w.ty;
      req_q_over_p <= w.qp;
      req_charge <= w.charge;
      do @(posedge clock); while (busy);
      sb.note_input(w);
      words_sent++;
   endtask

   task automatic load_entry(input logic [4:0] idx, input logic signed [63:0] v);
      req_word_type w;
      w = '{CMD_LOAD, idx, v, $urandom, $urandom, $urandom, 2'($urandom)};
      send_word(w);
   endtask

   task automatic compute(input logic signed [31:0] tx, input logic signed [31:0] ty,
                          input logic signed [31:0] qp, input logic signed [1:0] ch);
      req_word_type w;
      w = '{CMD_COMPUTE, 5'($urandom), {$urandom, $urandom}, tx, ty, qp, ch};
      send_word(w);
   endtask

   // Hold the sender until every predicted word has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // Write the mode only when idle; a trailing load may still be in flight.
   task automatic set_echo(input bit m);
      drain();
      repeat (64) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      sb.set_mode(m);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [63:0] rand_cov();
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v = {1'b1, 63'd0};
         1: v = {1'b0, {63{1'b1}}};
         2, 3: ;
         default: v = v >>> $urandom_range(8, 40);
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] rand_slope();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(11))
         0: v = 32'sh8000_0000;
         1: v = 32'sh7fff_ffff;
         2, 3: ;
         default: v = v >>> $urandom_range(3, 10);
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] rand_qp();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(11))
         0: v = 0;
         1: v = 32'sh8000_0000;
         2: v = 32'sh7fff_ffff;
         3: ;
         default: v = v >>> $urandom_range(2, 12);
      endcase
      return v;
   endfunction

   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int nloads;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_LOAD;
      req_element_index = '0;
      req_element_value = '0;
      req_tx_slope = '0;
      req_ty_slope = '0;
      req_q_over_p = '0;
      req_charge = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      idle_pct = 37;
      words_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the whole store first so no unwritten entry is ever read.
      for (int i = 0; i < N_OUT; i++) begin
         case (i % 4)
            0: load_entry(5'(i), {1'b0, {63{1'b1}}});
            1: load_entry(5'(i), {1'b1, 63'd0});
            2: load_entry(5'(i), 64'sd0);
            default: load_entry(5'(i), 64'sd1 <<< 48);
         endcase
      end
      load_entry(5'd31, 64'sd12345);                       // out of range, dropped
      compute(32'sd0, 32'sd0, 32'sd1 <<< 24, 2'sd1);        // straight track, saturates
      compute(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, -2'sd1);
      compute(32'sd1 <<< 23, -32'sd3 <<< 22, 32'sd0, 2'sd1); // zero q/p
      compute(32'sd1 <<< 22, 32'sd1 <<< 21, 32'sh7fff_ffff, -2'sd2); // charge pattern -2
      compute(32'sd1 <<< 22, 32'sd1 <<< 21, 32'sd1 <<< 20, 2'sd0);   // zero charge
      set_echo(1'b1);
      compute(32'sd0, 32'sd0, 32'sd0, 2'sd0);               // echo ignores q/p
      set_echo(1'b0);

      // Random: load sequences that usually end in a compute, with some noise mixed in.
      while (words_sent < 320) begin
         idle_pct = (words_sent < 130) ? 37 : (words_sent < 230) ? 81 : 0;
         if ($urandom_range(7) == 0) set_echo($urandom_range(1));
         nloads = ($urandom_range(5) == 0) ? N_OUT : $urandom_range(0, 6);
         for (int i = 0; i < nloads; i++) begin
            if (nloads == N_OUT) load_entry(5'(i), rand_cov());
            else if ($urandom_range(9) == 0) load_entry(5'($urandom_range(21, 31)), rand_cov());
            else load_entry(5'($urandom_range(0, 20)), rand_cov());
         end
         if ($urandom_range(9) != 0)
            compute(rand_slope(), rand_slope(), rand_qp(), 2'($urandom));
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
